### rtl/pdfs_pkg.sv
// ----------------------------------------------------------------------------
// pdfs_pkg
// Shared types and constants for the probe frame deframer and scaler.
// ----------------------------------------------------------------------------
package pdfs_pkg;

  // Widths of the stream fields.
  localparam int WORD_W    = 16;
  localparam int SCALE_W   = 32;
  localparam int PROD_W    = WORD_W + SCALE_W;
  localparam int SAMPLE_W  = 31;
  localparam int FIELD_W   = 3;
  localparam int REPEAT_W  = 16;
  localparam int COUNT_W   = 4;
  localparam int NUM_FIELDS = 8;
  localparam int NUM_PAIRS  = NUM_FIELDS / 2;
  localparam int PAIR_W     = 2 * SCALE_W;
  localparam int OUT_DATA_W = 56;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // Default parameter values.
  localparam int DEF_MAX_FIELD_COUNT = 8;
  localparam int DEF_SCALE_FRAC_BITS = 16;

  // Saturation limit of a scaled sample.
  localparam logic [SAMPLE_W-1:0] SAT_LIMIT = 31'h7FFF_FFFF;

  // Every scale resets to 1.0 in Q16.16.
  localparam logic [PAIR_W-1:0] SCALE_PAIR_RESET = 64'h0001_0000_0001_0000;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_FIELD_COUNT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_PAIR_A = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_PAIR_B = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_PAIR_C = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_PAIR_D = 3'd4;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMIT,
    ST_REPLAY
  } state_t;

  // Result of the shared multiply unit.
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                sat;
  } mul_result_t;

endpackage

### rtl/pdfs_mul_unit.sv
// ----------------------------------------------------------------------------
// pdfs_mul_unit
// Shared scaling unit: registered 16x32 multiply, then fraction shift and
// saturation to 31 bits.
// ----------------------------------------------------------------------------
module pdfs_mul_unit #(
  parameter int SCALE_FRAC_BITS = pdfs_pkg::DEF_SCALE_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pdfs_pkg::WORD_W-1:0]   sample,
  input  logic [pdfs_pkg::SCALE_W-1:0]  scale,
  output pdfs_pkg::mul_result_t         result
);

  logic [pdfs_pkg::PROD_W-1:0] prod;
  logic [pdfs_pkg::PROD_W-1:0] shifted;

  // Product register, loaded once per sample.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= pdfs_pkg::PROD_W'(sample) * pdfs_pkg::PROD_W'(scale);
    end
  end

  // Drop the fraction bits and clamp anything above the limit.
  always_comb begin
    shifted      = prod >> SCALE_FRAC_BITS;
    result.sat   = |shifted[pdfs_pkg::PROD_W-1:pdfs_pkg::SAMPLE_W];
    result.value = result.sat ? pdfs_pkg::SAT_LIMIT : shifted[pdfs_pkg::SAMPLE_W-1:0];
  end

endmodule

### rtl/probe_frame_deframer_scaler.sv
// ----------------------------------------------------------------------------
// probe_frame_deframer_scaler
// A header word with no frame gap gives no result. A sample word is accepted,
// passes through the shared multiplier and then loads the result register,
// giving one result. A header that reveals missing frames replays the held
// value of each active field in turn with the count of missing frames; a
// stalled consumer holds the sequencer. The input is not ready while a word
// is in the sequencer. Held values clear at reset at once.
//
// Top level: deframes a probe word stream, scales each sample by its field's
// Q16.16 factor with saturation, and replays held values across frame gaps.
// ----------------------------------------------------------------------------
module probe_frame_deframer_scaler #(
  parameter int MAX_FIELD_COUNT = pdfs_pkg::DEF_MAX_FIELD_COUNT,
  parameter int SCALE_FRAC_BITS = pdfs_pkg::DEF_SCALE_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pdfs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pdfs_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pdfs_pkg::WORD_W-1:0]         s_axis_tdata,  // [15:0] word_value
  // Output stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [30:0] sample_out, [33:31] field_number, [49:34] repeat_frames, rest zero
  output logic [pdfs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tuser,  // [0] saturated
  output logic                                m_axis_tlast   // last_of_run
);

  localparam logic [pdfs_pkg::COUNT_W-1:0] MAX_COUNT = pdfs_pkg::COUNT_W'(MAX_FIELD_COUNT);

  pdfs_pkg::state_t state, state_next;

  // Configuration registers.
  logic [pdfs_pkg::COUNT_W-1:0] field_count;
  logic [pdfs_pkg::PAIR_W-1:0]  scale_pair [pdfs_pkg::NUM_PAIRS];

  // Frame tracking.
  logic [pdfs_pkg::COUNT_W-1:0]  fields_left;
  logic [pdfs_pkg::WORD_W-1:0]   expected_frame;
  logic [pdfs_pkg::SAMPLE_W-1:0] held_values [pdfs_pkg::NUM_FIELDS];

  // Work registers of the sequencer.
  logic [pdfs_pkg::WORD_W-1:0]   word_reg;
  logic [pdfs_pkg::FIELD_W-1:0]  idx_reg;
  logic [pdfs_pkg::REPEAT_W-1:0] rep_gap;
  logic [pdfs_pkg::COUNT_W-1:0]  rep_count;

  // Output register.
  logic [pdfs_pkg::SAMPLE_W-1:0] out_sample;
  logic [pdfs_pkg::FIELD_W-1:0]  out_field;
  logic [pdfs_pkg::REPEAT_W-1:0] out_repeat;
  logic                          out_sat;
  logic                          out_last;

  // Combinational helpers.
  logic [pdfs_pkg::COUNT_W-1:0]  count;
  logic [pdfs_pkg::WORD_W-1:0]   gap;
  logic [pdfs_pkg::COUNT_W-1:0]  idx_wide;
  logic [pdfs_pkg::PAIR_W-1:0]   pair_sel;
  logic [pdfs_pkg::SCALE_W-1:0]  scale_sel;
  logic                          in_accept;
  logic                          is_header;
  logic                          out_free;
  logic                          mul_en;
  logic                          live_load;
  logic                          rep_load;
  logic                          rep_last;
  pdfs_pkg::mul_result_t         mul_res;

  // Active field count, clamped to the maximum.
  always_comb begin
    count     = (field_count > MAX_COUNT) ? MAX_COUNT : field_count;
    gap       = s_axis_tdata - expected_frame;
    idx_wide  = count - fields_left;
    is_header = (fields_left == '0);
    in_accept = s_axis_tvalid && s_axis_tready;
    out_free  = !m_axis_tvalid || m_axis_tready;
    pair_sel  = scale_pair[idx_reg[pdfs_pkg::FIELD_W-1:1]];
    scale_sel = idx_reg[0] ? pair_sel[pdfs_pkg::PAIR_W-1:pdfs_pkg::SCALE_W]
                           : pair_sel[pdfs_pkg::SCALE_W-1:0];
    rep_last  = ({1'b0, idx_reg} + pdfs_pkg::COUNT_W'(1)) == rep_count;
  end

  // Shared scaling unit.
  pdfs_mul_unit #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_mul (
    .clk    (clk),
    .en     (mul_en),
    .sample (word_reg),
    .scale  (scale_sel),
    .result (mul_res)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pdfs_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (!is_header) begin
            state_next = pdfs_pkg::ST_MUL;
          end else if (gap != '0 && count != '0) begin
            state_next = pdfs_pkg::ST_REPLAY;
          end
        end
      end
      pdfs_pkg::ST_MUL: begin
        state_next = pdfs_pkg::ST_EMIT;
      end
      pdfs_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = pdfs_pkg::ST_IDLE;
        end
      end
      pdfs_pkg::ST_REPLAY: begin
        if (out_free && rep_last) begin
          state_next = pdfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pdfs_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    mul_en        = 1'b0;
    live_load     = 1'b0;
    rep_load      = 1'b0;
    case (state)
      pdfs_pkg::ST_IDLE:   s_axis_tready = 1'b1;
      pdfs_pkg::ST_MUL:    mul_en        = 1'b1;
      pdfs_pkg::ST_EMIT:   live_load     = out_free;
      pdfs_pkg::ST_REPLAY: rep_load      = out_free;
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // Configuration is taken at any time; the user writes only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_count <= '0;
      for (int i = 0; i < pdfs_pkg::NUM_PAIRS; i++) begin
        scale_pair[i] <= pdfs_pkg::SCALE_PAIR_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pdfs_pkg::CFG_FIELD_COUNT:  field_count   <= cfg_data[pdfs_pkg::COUNT_W-1:0];
        pdfs_pkg::CFG_SCALE_PAIR_A: scale_pair[0] <= cfg_data;
        pdfs_pkg::CFG_SCALE_PAIR_B: scale_pair[1] <= cfg_data;
        pdfs_pkg::CFG_SCALE_PAIR_C: scale_pair[2] <= cfg_data;
        pdfs_pkg::CFG_SCALE_PAIR_D: scale_pair[3] <= cfg_data;
        default: begin
          field_count <= field_count;
        end
      endcase
    end
  end

  // Control state and held values.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= pdfs_pkg::ST_IDLE;
      fields_left    <= '0;
      expected_frame <= '0;
      m_axis_tvalid  <= 1'b0;
      for (int i = 0; i < pdfs_pkg::NUM_FIELDS; i++) begin
        held_values[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (in_accept) begin
        if (is_header) begin
          expected_frame <= s_axis_tdata + pdfs_pkg::WORD_W'(1);
          fields_left    <= count;
        end else begin
          fields_left <= fields_left - pdfs_pkg::COUNT_W'(1);
        end
      end
      if (live_load) begin
        held_values[idx_reg] <= mul_res.value;
      end
      if (live_load || rep_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers of the sequencer and the result register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      word_reg  <= s_axis_tdata;
      rep_gap   <= gap;
      rep_count <= count;
      idx_reg   <= is_header ? '0 : idx_wide[pdfs_pkg::FIELD_W-1:0];
    end else if (rep_load) begin
      idx_reg <= idx_reg + pdfs_pkg::FIELD_W'(1);
    end
    if (live_load) begin
      out_sample <= mul_res.value;
      out_field  <= idx_reg;
      out_repeat <= '0;
      out_sat    <= mul_res.sat;
      out_last   <= 1'b1;
    end else if (rep_load) begin
      out_sample <= held_values[idx_reg];
      out_field  <= idx_reg;
      out_repeat <= rep_gap;
      out_sat    <= 1'b0;
      out_last   <= rep_last;
    end
  end

  // Pack the result item.
  assign m_axis_tdata = {
    (pdfs_pkg::OUT_DATA_W - pdfs_pkg::SAMPLE_W - pdfs_pkg::FIELD_W - pdfs_pkg::REPEAT_W)'(0),
    out_repeat, out_field, out_sample
  };
  assign m_axis_tuser = out_sat;
  assign m_axis_tlast = out_last;

endmodule

### verif/pdfs_checker.sv
// ----------------------------------------------------------------------------
// pdfs_checker
// Watches the configuration, input and output channels of the probe frame
// deframer and scaler. It keeps its own copy of the registers and of the frame
// state, works out the results of every accepted word, and compares each
// accepted result with the oldest one still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdfs_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [pdfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pdfs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [pdfs_pkg::WORD_W-1:0]      s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [pdfs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                             m_axis_tuser,
  input  logic                             m_axis_tlast,
  output int                               mismatches,
  output int                               outstanding,
  output int                               words_seen,
  output int                               results_checked,
  output int                               replays_checked,
  output int                               clamps_checked
);

  localparam int PAD_LO = pdfs_pkg::SAMPLE_W + pdfs_pkg::FIELD_W + pdfs_pkg::REPEAT_W;

  typedef struct packed {
    logic [pdfs_pkg::SAMPLE_W-1:0] sample;
    logic [pdfs_pkg::FIELD_W-1:0]  field;
    logic [pdfs_pkg::REPEAT_W-1:0] repeat_frames;
    logic                          saturated;
    logic                          last_of_run;
  } probe_result_t;

  // Register copies and frame state.
  logic [pdfs_pkg::COUNT_W-1:0]  field_count_q;
  logic [pdfs_pkg::PAIR_W-1:0]   scale_pair_q [pdfs_pkg::NUM_PAIRS];
  logic [pdfs_pkg::COUNT_W-1:0]  fields_left_q;
  logic [pdfs_pkg::WORD_W-1:0]   next_frame_q;
  logic [pdfs_pkg::SAMPLE_W-1:0] held_q [pdfs_pkg::NUM_FIELDS];

  probe_result_t due_results[$];

  // Field count in use, clamped to the largest frame the block supports.
  function automatic logic [pdfs_pkg::COUNT_W-1:0] active_fields();
    if (field_count_q > pdfs_pkg::COUNT_W'(pdfs_pkg::DEF_MAX_FIELD_COUNT)) begin
      return pdfs_pkg::COUNT_W'(pdfs_pkg::DEF_MAX_FIELD_COUNT);
    end
    return field_count_q;
  endfunction

  function automatic logic [pdfs_pkg::SCALE_W-1:0] scale_for(
    input logic [pdfs_pkg::FIELD_W-1:0] f
  );
    logic [pdfs_pkg::PAIR_W-1:0] pair;
    pair = scale_pair_q[f[pdfs_pkg::FIELD_W-1:1]];
    return f[0] ? pair[pdfs_pkg::PAIR_W-1:pdfs_pkg::SCALE_W]
                : pair[pdfs_pkg::SCALE_W-1:0];
  endfunction

  // Works out the results of one word and queues them in order.
  task automatic deframe_word(input logic [pdfs_pkg::WORD_W-1:0] w);
    logic [pdfs_pkg::COUNT_W-1:0] cnt;
    logic [pdfs_pkg::WORD_W-1:0]  gap;
    logic [pdfs_pkg::FIELD_W-1:0] idx;
    logic [pdfs_pkg::PROD_W-1:0]  prod;
    probe_result_t                r;
    cnt = active_fields();
    if (fields_left_q == '0) begin
      // Header: a frame gap replays the held value of every active field once.
      gap = w - next_frame_q;
      if (gap != '0) begin
        for (int f = 0; f < int'(cnt); f++) begin
          r.sample        = held_q[f];
          r.field         = pdfs_pkg::FIELD_W'(f);
          r.repeat_frames = gap;
          r.saturated     = 1'b0;
          r.last_of_run   = (f + 1 == int'(cnt));
          due_results.push_back(r);
        end
      end
      next_frame_q  = w + 1'b1;
      fields_left_q = cnt;
    end else begin
      // Sample: scale, truncate, clamp and keep as the held value.
      idx  = pdfs_pkg::FIELD_W'(cnt - fields_left_q);
      prod = (pdfs_pkg::PROD_W'(w) * pdfs_pkg::PROD_W'(scale_for(idx)))
             >> pdfs_pkg::DEF_SCALE_FRAC_BITS;
      if (prod > pdfs_pkg::PROD_W'(pdfs_pkg::SAT_LIMIT)) begin
        r.sample    = pdfs_pkg::SAT_LIMIT;
        r.saturated = 1'b1;
      end else begin
        r.sample    = prod[pdfs_pkg::SAMPLE_W-1:0];
        r.saturated = 1'b0;
      end
      r.field         = idx;
      r.repeat_frames = '0;
      r.last_of_run   = 1'b1;
      held_q[idx]     = r.sample;
      due_results.push_back(r);
      fields_left_q = fields_left_q - 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what);
    if (mismatches < 10) begin
      $display("%0t ns: checker: %s", $realtime, what);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    probe_result_t exp_r;
    if (rst) begin
      field_count_q = '0;
      for (int i = 0; i < pdfs_pkg::NUM_PAIRS; i++) begin
        scale_pair_q[i] = pdfs_pkg::SCALE_PAIR_RESET;
      end
      fields_left_q = '0;
      next_frame_q  = '0;
      for (int i = 0; i < pdfs_pkg::NUM_FIELDS; i++) held_q[i] = '0;
      due_results.delete();
    end else begin
      // Register writes; unknown indexes change nothing.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pdfs_pkg::CFG_FIELD_COUNT:  field_count_q   = cfg_data[pdfs_pkg::COUNT_W-1:0];
          pdfs_pkg::CFG_SCALE_PAIR_A: scale_pair_q[0] = cfg_data;
          pdfs_pkg::CFG_SCALE_PAIR_B: scale_pair_q[1] = cfg_data;
          pdfs_pkg::CFG_SCALE_PAIR_C: scale_pair_q[2] = cfg_data;
          pdfs_pkg::CFG_SCALE_PAIR_D: scale_pair_q[3] = cfg_data;
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        words_seen++;
        deframe_word(s_axis_tdata);
      end

      // Compare each accepted result with the oldest one due.
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing due: tdata %h tuser %b tlast %b",
                                    m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
          exp_r = due_results.pop_front();
          results_checked++;
          if (exp_r.repeat_frames != '0) replays_checked++;
          if (exp_r.saturated) clamps_checked++;
          if (m_axis_tdata[pdfs_pkg::SAMPLE_W-1:0] != exp_r.sample ||
              m_axis_tdata[pdfs_pkg::SAMPLE_W +: pdfs_pkg::FIELD_W] != exp_r.field ||
              m_axis_tdata[pdfs_pkg::SAMPLE_W+pdfs_pkg::FIELD_W +: pdfs_pkg::REPEAT_W]
                != exp_r.repeat_frames ||
              m_axis_tdata[pdfs_pkg::OUT_DATA_W-1:PAD_LO] != '0 ||
              m_axis_tuser != exp_r.saturated ||
              m_axis_tlast != exp_r.last_of_run) begin
            report_mismatch($sformatf({"expected sample %h field %0d repeat %0d sat %b ",
                                       "last %b; got tdata %h tuser %b tlast %b"},
                                      exp_r.sample, exp_r.field, exp_r.repeat_frames,
                                      exp_r.saturated, exp_r.last_of_run,
                                      m_axis_tdata, m_axis_tuser, m_axis_tlast));
          end
        end
      end
    end
    outstanding = due_results.size();
  end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the probe frame deframer and scaler with directed frames, then with
// random phases of register settings and mostly well-formed frames, with
// random idle bursts on both streams and one long output stall. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_ITEMS    = 120;
  localparam int QUIET_TAIL      = 35;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TIMEOUT_NS      = 1_000_000;

  logic                             clk;
  logic                             rst;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [pdfs_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [pdfs_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [pdfs_pkg::WORD_W-1:0]      s_axis_tdata;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [pdfs_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
  logic                             m_axis_tuser;
  logic                             m_axis_tlast;

  int mismatches, outstanding, words_seen;
  int results_checked, replays_checked, clamps_checked;

  // Stimulus bookkeeping.
  bit                           idle_on;
  bit                           hold_off_req;
  logic [pdfs_pkg::COUNT_W-1:0] field_count_set;
  logic [pdfs_pkg::WORD_W-1:0]  next_frame;
  int                           items_sent;
  int                           phases;

  probe_frame_deframer_scaler dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  pdfs_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .words_seen      (words_seen),
    .results_checked (results_checked),
    .replays_checked (replays_checked),
    .clamps_checked  (clamps_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: done, errors");
    $finish;
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at a falling edge after the write is taken.
  task automatic write_reg(input logic [pdfs_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [pdfs_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == pdfs_pkg::CFG_FIELD_COUNT) field_count_set = data[pdfs_pkg::COUNT_W-1:0];
    @(negedge clk);
  endtask

  // Offers one word; tvalid stays high on return so the next word follows.
  task automatic send_word(input logic [pdfs_pkg::WORD_W-1:0] w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // Lets the block drain so the registers can be written.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic int active_count();
    return (field_count_set > pdfs_pkg::COUNT_W'(pdfs_pkg::DEF_MAX_FIELD_COUNT)) ?
           pdfs_pkg::DEF_MAX_FIELD_COUNT : int'(field_count_set);
  endfunction

  function automatic logic [pdfs_pkg::WORD_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return pdfs_pkg::WORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [pdfs_pkg::SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return pdfs_pkg::SCALE_PAIR_RESET[pdfs_pkg::SCALE_W-1:0];
      3:       return $urandom;
      default: return pdfs_pkg::SCALE_W'($urandom_range(0, 32'h0004_0000));
    endcase
  endfunction

  function automatic logic [pdfs_pkg::COUNT_W-1:0] pick_field_count();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return pdfs_pkg::COUNT_W'(pdfs_pkg::DEF_MAX_FIELD_COUNT);
      3:       return pdfs_pkg::COUNT_W'(1);
      default: return pdfs_pkg::COUNT_W'($urandom_range(1, 15));
    endcase
  endfunction

  // One header, mostly on time, then the samples of the frame; now and then
  // the frame is cut short or runs long.
  task automatic send_frame();
    logic [pdfs_pkg::WORD_W-1:0] hdr;
    int                          act;
    int                          n;
    act = active_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: hdr = next_frame;
      6, 7:             hdr = next_frame + pdfs_pkg::WORD_W'($urandom_range(1, 4));
      default:          hdr = pdfs_pkg::WORD_W'($urandom);
    endcase
    send_word(hdr);
    next_frame = hdr + 1'b1;
    n = act;
    if ($urandom_range(0, 11) == 0) n = $urandom_range(0, act + 1);
    for (int i = 0; i < n; i++) send_word(pick_sample());
  endtask

  initial begin
    int random_start;
    rst             = 1'b1;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    idle_on         = 1'b1;
    hold_off_req    = 1'b0;
    field_count_set = '0;
    next_frame      = '0;
    items_sent      = 0;
    phases          = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: three fields at 1.0, 2.0 and the largest scale.
    write_reg(pdfs_pkg::CFG_FIELD_COUNT, 64'd3);
    write_reg(pdfs_pkg::CFG_SCALE_PAIR_A, {32'h0002_0000, 32'h0001_0000});
    write_reg(pdfs_pkg::CFG_SCALE_PAIR_B, {32'h0000_0000, 32'hFFFF_FFFF});
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'hFFFF);
    send_word(16'hFFFF);
    // A gap replays the held values, then a gap that wraps the frame number.
    send_word(16'h0004);
    send_word(16'h0000);
    send_word(16'h8000);
    send_word(16'h0001);
    send_word(16'hFFFF);
    repeat (3) send_word(pick_sample());
    send_word(16'h0000);
    repeat (3) send_word(pick_sample());
    settle();

    // No fields: every word is a header and gaps emit nothing.
    write_reg(pdfs_pkg::CFG_FIELD_COUNT, 64'd0);
    send_word(16'h0009);
    send_word(16'h000A);
    settle();

    // Count above the maximum acts as eight; fields never sampled replay zero.
    write_reg(pdfs_pkg::CFG_FIELD_COUNT, 64'd15);
    write_reg(pdfs_pkg::CFG_SCALE_PAIR_C, {$urandom, $urandom});
    write_reg(pdfs_pkg::CFG_SCALE_PAIR_D, '1);
    send_word(16'h0014);
    send_word(pick_sample());
    send_word(pick_sample());
    settle();

    // Count lowered within a frame: the field index wraps around.
    write_reg(pdfs_pkg::CFG_FIELD_COUNT, 64'd2);
    repeat (6) send_word(pick_sample());
    settle();

    // Writes to indexes with no register behind them.
    for (int k = int'(pdfs_pkg::CFG_SCALE_PAIR_D) + 1; k < (1 << pdfs_pkg::CFG_INDEX_W);
         k++) begin
      write_reg(pdfs_pkg::CFG_INDEX_W'(k), {$urandom, $urandom});
    end
    next_frame = 16'h0015;

    // Random phases of settings and frames.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      settle();
      phases++;
      if (phases == 2) begin
        write_reg(pdfs_pkg::CFG_FIELD_COUNT,
                  pdfs_pkg::CFG_DATA_W'(pdfs_pkg::DEF_MAX_FIELD_COUNT));
      end else begin
        write_reg(pdfs_pkg::CFG_FIELD_COUNT, 64'(pick_field_count()));
      end
      if ($urandom_range(0, 1)) begin
        write_reg(pdfs_pkg::CFG_SCALE_PAIR_A, {pick_scale(), pick_scale()});
      end
      if ($urandom_range(0, 1)) begin
        write_reg(pdfs_pkg::CFG_SCALE_PAIR_B, {pick_scale(), pick_scale()});
      end
      if ($urandom_range(0, 1)) begin
        write_reg(pdfs_pkg::CFG_SCALE_PAIR_C, {pick_scale(), pick_scale()});
      end
      if ($urandom_range(0, 1)) begin
        write_reg(pdfs_pkg::CFG_SCALE_PAIR_D, {pick_scale(), pick_scale()});
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(pdfs_pkg::CFG_INDEX_W'($urandom_range(int'(pdfs_pkg::CFG_SCALE_PAIR_D) + 1,
                                                        (1 << pdfs_pkg::CFG_INDEX_W) - 1)),
                  {$urandom, $urandom});
      end
      // The long output stall lands on a full-size phase so the input backs up.
      if (phases == 2) hold_off_req = 1'b1;
      repeat ($urandom_range(2, 6)) begin
        if (items_sent - random_start >= RANDOM_ITEMS) break;
        idle_on = (items_sent - random_start) < RANDOM_ITEMS - QUIET_TAIL;
        send_frame();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("tb: %0d words over %0d setting phases, %0d results checked",
             words_seen, phases, results_checked);
    $display("tb: %0d replayed held values, %0d clamped samples, one long output stall",
             replays_checked, clamps_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
